### design/ffrwl_pkg.sv
// Shared types, constants and helpers for the FIFO fair reader-writer lock.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffrwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int REQUESTERS  = 256;
    localparam int MAX_RESULTS = 16;

    localparam int ID_W       = 8;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int RC_W       = 9;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W      = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W    = ID_W + 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [RC_W-1:0] READER_MAX = {RC_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_RD_REQ = 2'd0,
        CMD_WR_REQ = 2'd1,
        CMD_RD_REL = 2'd2,
        CMD_WR_REL = 2'd3
    } cmd_code_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANT  = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_MISUSE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_FETCH = 2'd2,
        ST_CHECK = 2'd3
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic drain;
        logic flush;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic head_dirty;
        logic drain_ok;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

    // Advance a queue pointer with wrap at the queue depth
    function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

endpackage

### design/ffrwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the wait queue entries; no package dependency.
module ffrwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### design/ffrwl_ctrl.sv
// Sequencing state machine for the reader-writer lock.
// Depends on ffrwl_pkg; drives datapath commands from datapath status.
module ffrwl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ffrwl_pkg::dp_status_t  sts,
    output ffrwl_pkg::ctrl_cmd_t   cmd
);

    import ffrwl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = sts.head_dirty ? ST_FETCH : ST_CHECK;
            end
            ST_FETCH:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.drain_ok)
                begin
                    if (!sts.pend_valid || sts.out_free)
                        state_next = ST_FETCH;
                end
                else if (!sts.pend_valid || sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_FETCH:
            begin
                cmd = '0;
            end
            ST_CHECK:
            begin
                cmd.drain = sts.drain_ok && (!sts.pend_valid || sts.out_free);
                cmd.flush = !sts.drain_ok && sts.pend_valid && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/ffrwl_dp.sv
// Lock state, wait queue, pending result and output register.
// Depends on ffrwl_pkg and ffrwl_ram; steered by ffrwl_ctrl commands.
module ffrwl_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffrwl_pkg::ctrl_cmd_t          cmd,
    output ffrwl_pkg::dp_status_t         sts,
    input  logic [ffrwl_pkg::CMD_W-1:0]   in_cmd,
    input  logic [ffrwl_pkg::ID_W-1:0]    in_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffrwl_pkg::KIND_W-1:0]  out_kind,
    output logic [ffrwl_pkg::ID_W-1:0]    out_id,
    output logic                          out_wr,
    output logic                          out_last
);

    import ffrwl_pkg::*;

    // Captured request
    cmd_code_t         cmd_reg;
    logic [ID_W-1:0]   id_reg;

    // Lock state and queue control
    mode_t             mode_reg,  mode_next;
    logic [RC_W-1:0]   rc_reg,    rc_next;
    logic [QPTR_W-1:0] head_reg,  head_next;
    logic [QPTR_W-1:0] tail_reg,  tail_next;
    logic [QCNT_W-1:0] cnt_reg,   cnt_next;
    logic [RES_W-1:0]  res_reg,   res_next;

    // Pending result, held until the next one shows whether it is last
    logic              pend_valid_reg, pend_valid_next;
    kind_t             pend_kind_reg,  pend_kind_next;
    logic [ID_W-1:0]   pend_id_reg,    pend_id_next;
    logic              pend_wr_reg,    pend_wr_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_wr_reg;
    logic              out_last_reg;

    // Queue storage
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ID_W-1:0]    head_id;
    logic               head_wr;

    logic               ex_enq;
    logic               ex_pop;
    logic               out_free;
    logic               out_load;

    assign head_id = ram_rdata[ID_W-1:0];
    assign head_wr = ram_rdata[ID_W];

    ffrwl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= cmd_code_t'(in_cmd);
            id_reg  <= in_id & ID_W'(REQUESTERS - 1);
        end
    end

    // Evaluate the request, then grant queued readers one at a time
    always_comb
    begin
        logic do_ho;
        logic do_emit;
        kind_t e_kind;
        logic e_wr;
        logic [ID_W-1:0] e_id;
        logic [RC_W-1:0] rc_dec;

        mode_next       = mode_reg;
        rc_next         = rc_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        pend_wr_next    = pend_wr_reg;
        ram_we          = 1'b0;
        ram_wdata       = {1'b0, id_reg};
        ex_enq          = 1'b0;
        ex_pop          = 1'b0;
        do_ho           = 1'b0;
        do_emit         = 1'b0;
        e_kind          = KIND_GRANT;
        e_wr            = 1'b0;
        e_id            = id_reg;
        rc_dec          = rc_reg - 1'b1;

        case (cmd_reg)
            CMD_RD_REQ:
            begin
                if (mode_reg == MODE_FREE)
                begin
                    mode_next = MODE_READ;
                    rc_next   = RC_W'(1);
                    do_emit   = 1'b1;
                end
                else if (mode_reg == MODE_READ && cnt_reg == '0 && rc_reg != READER_MAX)
                begin
                    rc_next = rc_reg + 1'b1;
                    do_emit = 1'b1;
                end
                else if (cnt_reg != QCNT_W'(QUEUE_DEPTH))
                begin
                    ex_enq    = 1'b1;
                    ram_wdata = {1'b0, id_reg};
                end
                else
                begin
                    do_emit = 1'b1;
                    e_kind  = KIND_REJECT;
                end
            end
            CMD_WR_REQ:
            begin
                if (mode_reg == MODE_FREE)
                begin
                    mode_next = MODE_WRITE;
                    do_emit   = 1'b1;
                    e_wr      = 1'b1;
                end
                else if (cnt_reg != QCNT_W'(QUEUE_DEPTH))
                begin
                    ex_enq    = 1'b1;
                    ram_wdata = {1'b1, id_reg};
                end
                else
                begin
                    do_emit = 1'b1;
                    e_kind  = KIND_REJECT;
                end
            end
            CMD_RD_REL:
            begin
                if (mode_reg != MODE_READ || rc_reg == '0)
                begin
                    do_emit = 1'b1;
                    e_kind  = KIND_MISUSE;
                end
                else if (rc_dec == '0)
                begin
                    do_ho = 1'b1;
                end
                else
                begin
                    rc_next = rc_dec;
                end
            end
            CMD_WR_REL:
            begin
                if (mode_reg != MODE_WRITE)
                begin
                    do_emit = 1'b1;
                    e_kind  = KIND_MISUSE;
                end
                else
                begin
                    do_ho = 1'b1;
                end
            end
            default:
            begin
                do_emit = 1'b0;
            end
        endcase

        // Hand the lock to the queue head, or free it
        if (do_ho)
        begin
            if (cnt_reg == '0)
            begin
                mode_next = MODE_FREE;
                rc_next   = '0;
            end
            else
            begin
                ex_pop    = 1'b1;
                do_emit   = 1'b1;
                e_id      = head_id;
                e_wr      = head_wr;
                mode_next = head_wr ? MODE_WRITE : MODE_READ;
                rc_next   = head_wr ? '0 : RC_W'(1);
            end
        end

        if (cmd.exec)
        begin
            ram_we          = ex_enq;
            pend_valid_next = do_emit;
            pend_kind_next  = e_kind;
            pend_id_next    = e_id;
            pend_wr_next    = e_wr;
            res_next        = do_emit ? RES_W'(1) : '0;
            if (ex_enq)
            begin
                tail_next = qptr_inc(tail_reg);
                cnt_next  = cnt_reg + 1'b1;
            end
            else if (ex_pop)
            begin
                head_next = qptr_inc(head_reg);
                cnt_next  = cnt_reg - 1'b1;
            end
        end
        else if (cmd.drain)
        begin
            // Grant the reader at the head; the older pending result goes out
            head_next       = qptr_inc(head_reg);
            cnt_next        = cnt_reg - 1'b1;
            rc_next         = rc_reg + 1'b1;
            res_next        = res_reg + 1'b1;
            pend_valid_next = 1'b1;
            pend_kind_next  = KIND_GRANT;
            pend_id_next    = head_id;
            pend_wr_next    = 1'b0;
        end
        else
        begin
            mode_next = mode_reg;
            rc_next   = rc_reg;
            if (cmd.flush)
                pend_valid_next = 1'b0;
        end
    end

    // Lock state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_FREE;
            rc_reg         <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            res_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            rc_reg         <= rc_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
            res_reg        <= res_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Pending result payload
    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        pend_wr_reg   <= pend_wr_next;
    end

    // Output register: load the pending result, drop it once taken
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (cmd.drain && pend_valid_reg) || cmd.flush;

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_id_reg   <= pend_id_reg;
            out_wr_reg   <= pend_wr_reg;
            out_last_reg <= cmd.flush;
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.head_dirty = ex_enq || ex_pop;
        sts.drain_ok   = mode_reg == MODE_READ && cnt_reg != '0
                         && res_reg != RES_W'(MAX_RESULTS)
                         && rc_reg != READER_MAX && !head_wr;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_id    = out_id_reg;
    assign out_wr    = out_wr_reg;
    assign out_last  = out_last_reg;

endmodule

### design/fifo_fair_reader_writer_lock.sv
// Top level of the FIFO fair reader-writer lock manager.
// Depends on ffrwl_pkg, ffrwl_ctrl and ffrwl_dp.
//
//  channel   direction  tdata (low bit up)                     tuser           tlast
//  s_axis    in         requester_id[7:0], zero pad to 8       command[1:0]    -
//  m_axis    out        granted_id[7:0], grant_is_write, pad   result_kind     last
//
// One request at a time: the accept state, then the evaluate state and the check state,
// plus a fetch state when the request touches the wait queue (queue RAM read).
// Each cascaded reader grant adds a check and a head re-read.
// Reset clears the lock state, queue pointers and handshakes; queue storage is not cleared.
// A stalled m_axis holds the results in the output register and the pending stage.
module fifo_fair_reader_writer_lock (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ffrwl_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // requester_id
    input  logic [ffrwl_pkg::CMD_W-1:0]       s_axis_tuser,  // command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ffrwl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // granted_id, grant_is_write
    output logic [ffrwl_pkg::KIND_W-1:0]      m_axis_tuser,  // result_kind
    output logic                              m_axis_tlast   // last
);

    import ffrwl_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        sts;
    logic [ID_W-1:0]   out_id;
    logic              out_wr;

    ffrwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffrwl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_cmd    (s_axis_tuser),
        .in_id     (s_axis_tdata[ID_W-1:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_id    (out_id),
        .out_wr    (out_wr),
        .out_last  (m_axis_tlast)
    );

    // Pack the result payload
    assign m_axis_tdata = {{(OUT_DATA_W - ID_W - 1){1'b0}}, out_wr, out_id};

    // A write grant never starts a reader cascade
    a_write_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[ID_W] |-> m_axis_tlast)
        else $error("write grant not marked last");

    // No request is taken while a result of the previous one is held back
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !sts.pend_valid)
        else $error("request accepted with a pending result");

    // One request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back accept");

endmodule

### test/fifo_fair_reader_writer_lock_test.sv
// Testbench for the FIFO fair reader-writer lock manager.
// Drives lock requests, predicts every grant, reject and misuse result, and checks them.
// Depends on ffrwl_pkg and fifo_fair_reader_writer_lock.
module fifo_fair_reader_writer_lock_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ffrwl_pkg::*;

    localparam int CYCLE_LIMIT     = 800000;
    localparam int LONG_STALL      = 300;
    localparam int RANDOM_REQUESTS = 270;
    localparam int QUIET_TAIL      = 60;
    localparam int DRAIN_CYCLES    = 64;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] id;
        logic            wr;
        logic            last;
    } lock_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // requester_id
    logic [CMD_W-1:0]      s_axis_tuser  = '0;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // granted_id, grant_is_write, pad
    logic [KIND_W-1:0]     m_axis_tuser;         // result_kind
    logic                  m_axis_tlast;         // last

    // Predicted lock state
    mode_t             lock_mode;
    logic [RC_W-1:0]   reader_count;
    logic [ID_W-1:0]   waiter_id [QUEUE_DEPTH];
    logic              waiter_wr [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wait_head;
    logic [QPTR_W-1:0] wait_tail;
    logic [QCNT_W-1:0] wait_count;
    int                results_in_event;

    lock_result_t expected_results[$];
    lock_result_t got_result;
    lock_result_t want_result;

    int   error_count  = 0;
    int   cycle_count  = 0;
    logic idling_on    = 1'b1;
    int   stall_ticket = 0;
    int   stall_seen   = 0;
    int   sink_hold    = 0;

    fifo_fair_reader_writer_lock u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance a wait queue pointer with wrap
    function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    // Append one result of the current request, capped at the result limit
    function automatic void post_result(input kind_t kind, input logic [ID_W-1:0] id,
                                        input logic wr);
        lock_result_t r;
        if (results_in_event >= MAX_RESULTS)
            return;
        r.kind = kind;
        r.id   = id;
        r.wr   = wr;
        r.last = 1'b0;
        expected_results.push_back(r);
        results_in_event++;
    endfunction

    // Hand the lock to the head waiter, or free it when nobody waits
    function automatic void pass_lock_on();
        logic [ID_W-1:0] id;
        logic            wr;
        if (wait_count == 0)
        begin
            lock_mode    = MODE_FREE;
            reader_count = '0;
            return;
        end
        id         = waiter_id[wait_head];
        wr         = waiter_wr[wait_head];
        wait_head  = next_slot(wait_head);
        wait_count = wait_count - 1'b1;
        if (wr)
        begin
            lock_mode    = MODE_WRITE;
            reader_count = '0;
        end
        else
        begin
            lock_mode    = MODE_READ;
            reader_count = RC_W'(1);
        end
        post_result(KIND_GRANT, id, wr);
    endfunction

    // Queue a waiter; report a reject when the queue is full
    function automatic void queue_or_reject(input logic [ID_W-1:0] id, input logic wr);
        if (wait_count >= QUEUE_DEPTH)
        begin
            post_result(KIND_REJECT, id, 1'b0);
            return;
        end
        waiter_id[wait_tail] = id;
        waiter_wr[wait_tail] = wr;
        wait_tail  = next_slot(wait_tail);
        wait_count = wait_count + 1'b1;
    endfunction

    // Work out the results of one accepted request and update the lock state
    function automatic void predict_lock_event(input cmd_code_t cmd,
                                               input logic [ID_W-1:0] id);
        lock_result_t r;
        results_in_event = 0;
        case (cmd)
            CMD_RD_REQ:
            begin
                if (lock_mode == MODE_FREE)
                begin
                    lock_mode    = MODE_READ;
                    reader_count = RC_W'(1);
                    post_result(KIND_GRANT, id, 1'b0);
                end
                else if (lock_mode == MODE_READ && wait_count == 0 &&
                         reader_count < READER_MAX)
                begin
                    reader_count = reader_count + 1'b1;
                    post_result(KIND_GRANT, id, 1'b0);
                end
                else
                    queue_or_reject(id, 1'b0);
            end
            CMD_WR_REQ:
            begin
                if (lock_mode == MODE_FREE)
                begin
                    lock_mode = MODE_WRITE;
                    post_result(KIND_GRANT, id, 1'b1);
                end
                else
                    queue_or_reject(id, 1'b1);
            end
            CMD_RD_REL:
            begin
                if (lock_mode != MODE_READ || reader_count == 0)
                    post_result(KIND_MISUSE, id, 1'b0);
                else
                begin
                    reader_count = reader_count - 1'b1;
                    if (reader_count == 0)
                        pass_lock_on();
                end
            end
            default:
            begin
                if (lock_mode != MODE_WRITE)
                    post_result(KIND_MISUSE, id, 1'b0);
                else
                    pass_lock_on();
            end
        endcase

        // Cascade readers at the head while the lock stays in read mode
        while (lock_mode == MODE_READ && wait_count > 0 &&
               results_in_event < MAX_RESULTS && reader_count < READER_MAX &&
               !waiter_wr[wait_head])
        begin
            reader_count = reader_count + 1'b1;
            post_result(KIND_GRANT, waiter_id[wait_head], 1'b0);
            wait_head  = next_slot(wait_head);
            wait_count = wait_count - 1'b1;
        end

        if (results_in_event > 0)
        begin
            r      = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endfunction

    // Offer one request, with an optional gap, and predict it once accepted
    task automatic send_request(input cmd_code_t cmd, input logic [ID_W-1:0] id);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_lock_event(cmd, id);
    endtask

    // Hold the sender until every expected result has arrived
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Pick a request from the predicted state: fill the queue, then release holders
    task automatic send_shaped_requests(input int count, input int quiet_from);
        int        i;
        int        pick;
        bit        filling;
        cmd_code_t cmd;
        filling = 1'b1;
        for (i = 0; i < count; i++)
        begin
            if (i == quiet_from)
                idling_on = 1'b0;
            if (wait_count == QUEUE_DEPTH && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            if (lock_mode == MODE_FREE || $urandom_range(0, 19) == 0)
                filling = ~filling | (lock_mode == MODE_FREE);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                cmd = cmd_code_t'($urandom_range(0, 3));
            else if (filling || lock_mode == MODE_FREE)
                cmd = (pick < 60) ? CMD_RD_REQ : CMD_WR_REQ;
            else
                cmd = (lock_mode == MODE_READ) ? CMD_RD_REL : CMD_WR_REL;
            send_request(cmd, ID_W'($urandom_range(0, 255)));
        end
    endtask

    // Grants, joins, hand-over in both directions and misuse in every mode
    task automatic test_directed_events();
        send_request(CMD_RD_REQ, 8'h00);
        send_request(CMD_RD_REQ, 8'hC3);
        send_request(CMD_WR_REQ, 8'hFF);
        send_request(CMD_RD_REQ, 8'h55);
        send_request(CMD_WR_REL, 8'hAA);
        send_request(CMD_RD_REL, 8'h3C);
        send_request(CMD_RD_REL, 8'h00);
        send_request(CMD_RD_REL, 8'h01);
        send_request(CMD_WR_REQ, 8'h0F);
        send_request(CMD_WR_REL, 8'h02);
        send_request(CMD_RD_REL, 8'h03);
        send_request(CMD_WR_REL, 8'h04);
        send_request(CMD_WR_REL, 8'h80);
        send_request(CMD_RD_REL, 8'h7F);
        wait_all_results();
    endtask

    // Fill the queue behind a writer, hit both rejects, then cascade a full run
    task automatic test_queue_full_cascade();
        int i;
        send_request(CMD_WR_REQ, 8'h10);
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_request(CMD_RD_REQ, ID_W'($urandom_range(0, 255)));
        send_request(CMD_RD_REQ, 8'hFE);
        send_request(CMD_WR_REQ, 8'h01);
        send_request(CMD_WR_REL, 8'h10);
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_request(CMD_RD_REL, ID_W'($urandom_range(0, 255)));
        wait_all_results();
    endtask

    // Hold off the result side for a long stretch while requests keep coming
    task automatic test_output_stall();
        int i;
        stall_ticket++;
        for (i = 0; i < 40; i++)
            send_request(cmd_code_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 255)));
        wait_all_results();
    endtask

    // Shaped random traffic, with a stretch at the end where neither side idles
    task automatic test_random_traffic();
        send_shaped_requests(RANDOM_REQUESTS, RANDOM_REQUESTS - QUIET_TAIL);
        wait_all_results();
    endtask

    initial
    begin
        lock_mode    = MODE_FREE;
        reader_count = '0;
        wait_head    = '0;
        wait_tail    = '0;
        wait_count   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_events();
        test_queue_full_cascade();
        test_output_stall();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Drive the result-side ready: long hold on request, else random bursts
    always @(posedge clk)
    begin
        if (stall_ticket != stall_seen)
        begin
            stall_seen = stall_ticket;
            sink_hold  = LONG_STALL;
        end
        if (sink_hold > 0)
        begin
            sink_hold = sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            sink_hold = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_result.kind = kind_t'(m_axis_tuser);
            got_result.id   = m_axis_tdata[ID_W-1:0];
            got_result.wr   = m_axis_tdata[ID_W];
            got_result.last = m_axis_tlast;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: kind %0d id %0d wr %0d last %0d",
                         $realtime, got_result.kind, got_result.id, got_result.wr,
                         got_result.last);
                error_count++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (got_result != want_result)
                begin
                    $display("%0t: result mismatch: expected kind %0d id %0d wr %0d last %0d",
                             $realtime, want_result.kind, want_result.id, want_result.wr,
                             want_result.last);
                    $display("%0t:                  actual kind %0d id %0d wr %0d last %0d",
                             $realtime, got_result.kind, got_result.id, got_result.wr,
                             got_result.last);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
